@@ hdl/tta_pkg.sv @@
// Shared constants and types for the tile address generator.
package tta_pkg;

    // Fixed widths of the transaction fields
    localparam int OFFSET_W   = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int ELEM_W     = 4;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIMS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd2;

    typedef logic [OFFSET_W-1:0]   t_offset;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [ELEM_W-1:0]     t_elem_bytes;

endpackage

@@ hdl/tta_channels.sv @@
// Valid/ready channel interfaces: request, response and configuration write.
interface tta_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface tta_rsp_if
    import tta_pkg::*;
;
    logic    valid;
    logic    ready;
    t_offset source_offset;
    logic    last;

    modport source (output valid, output source_offset, output last, input ready);
    modport sink   (input valid, input source_offset, input last, output ready);
endinterface

interface tta_cfg_if
    import tta_pkg::*;
;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/tta_stride_calc.sv @@
// Sequential per-axis byte stride calculation, one axis per cycle.
module tta_stride_calc
    import tta_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_elem_bytes         i_elem_bytes,
    input  logic [DIM_BITS-1:0] i_dim [MAX_RANK],
    output t_offset             o_step [MAX_RANK],
    output logic                o_busy
);

    localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANK - 1);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_offset          r_acc;
    t_offset          r_step [MAX_RANK];
    t_offset          n_acc;

    // Running product of inner sizes times element size, modulo 2^32
    assign n_acc = OFFSET_W'(r_acc * OFFSET_W'(i_dim[r_idx]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_acc  <= OFFSET_W'(1);
            for (int a = 0; a < MAX_RANK; a++) begin
                r_step[a] <= OFFSET_W'(1);
            end
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_acc  <= OFFSET_W'(i_elem_bytes);
        end else if (r_busy) begin
            r_step[r_idx] <= r_acc;
            r_acc         <= n_acc;
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign o_step = r_step;
    assign o_busy = r_busy;

endmodule

@@ hdl/tensor_tile_address_generator.sv @@
// Top level of the N-dimensional tile address generator.
//
//  channel | dir | payload                    | accepted when
//  i_req   | in  | restart                    | i_req.valid && i_req.ready
//  o_rsp   | out | source_offset, last        | o_rsp.valid && o_rsp.ready
//  i_cfg   | in  | index, data                | i_cfg.valid && i_cfg.ready
//
// One request per clock is accepted while the pipeline does not stall and no
// stride rebuild is under way; each request passes through the counter, per-axis
// multiply and offset sum stages. Each stage holds its transaction only while the
// stage after it is full. After every configuration write the strides are rebuilt
// by one shared multiplier, one axis per cycle, while i_req.ready stays low.
// Reset (synchronous, active low) restores all sizes and repeats to 1,
// element size to 1 and all counters to zero.
module tensor_tile_address_generator
    import tta_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tta_req_if.sink  i_req,
    tta_rsp_if.source o_rsp,
    tta_cfg_if.sink  i_cfg
);

    localparam int FIELD_W = MAX_RANK * DIM_BITS;
    localparam int PAD_W   = (FIELD_W > CFG_DATA_W) ? FIELD_W : CFG_DATA_W;

    // Reset value: a one in the low bit of every field that fits in the register
    function automatic t_cfg_data ones_per_field();
        t_cfg_data v;
        v = '0;
        for (int a = 0; a < MAX_RANK; a++) begin
            if (a * DIM_BITS < CFG_DATA_W) begin
                v[a * DIM_BITS] = 1'b1;
            end
        end
        return v;
    endfunction

    // Configuration registers
    t_cfg_data   r_input_dims;
    t_cfg_data   r_repeat_counts;
    t_elem_bytes r_elem_bytes;
    logic        r_recalc;
    logic        cfg_acc;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_dims    <= ones_per_field();
            r_repeat_counts <= ones_per_field();
            r_elem_bytes    <= ELEM_W'(1);
            r_recalc        <= 1'b0;
        end else begin
            r_recalc <= cfg_acc;
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    CFG_INPUT_DIMS:    r_input_dims    <= i_cfg.data;
                    CFG_REPEAT_COUNTS: r_repeat_counts <= i_cfg.data;
                    CFG_ELEMENT_BYTES: r_elem_bytes    <= i_cfg.data[ELEM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Effective per-axis sizes and repeat counts (zero reads as one)
    logic [PAD_W-1:0]    dims_pad;
    logic [PAD_W-1:0]    reps_pad;
    logic [DIM_BITS-1:0] dim_eff [MAX_RANK];
    logic [DIM_BITS-1:0] rep_eff [MAX_RANK];

    assign dims_pad = PAD_W'(r_input_dims);
    assign reps_pad = PAD_W'(r_repeat_counts);

    always_comb begin
        for (int a = 0; a < MAX_RANK; a++) begin
            dim_eff[a] = dims_pad[a * DIM_BITS +: DIM_BITS];
            rep_eff[a] = reps_pad[a * DIM_BITS +: DIM_BITS];
            if (dim_eff[a] == '0) dim_eff[a] = DIM_BITS'(1);
            if (rep_eff[a] == '0) rep_eff[a] = DIM_BITS'(1);
        end
    end

    // Byte strides per axis
    t_offset step [MAX_RANK];
    logic    stride_busy;

    tta_stride_calc #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_stride (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_recalc),
        .i_elem_bytes (r_elem_bytes),
        .i_dim        (dim_eff),
        .o_step       (step),
        .o_busy       (stride_busy)
    );

    // Pipeline flow control
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_load, s2_load, s1_load, req_acc;

    assign out_load    = !r_out_valid || o_rsp.ready;
    assign s2_load     = !r_s2_valid || out_load;
    assign s1_load     = !r_s1_valid || s2_load;
    assign i_req.ready = s1_load && !stride_busy && !r_recalc;
    assign req_acc     = i_req.valid && i_req.ready;

    // Axis counters: position of the element the next request emits
    logic [DIM_BITS-1:0] r_coord [MAX_RANK];
    logic [DIM_BITS-1:0] r_rep   [MAX_RANK];
    logic [DIM_BITS-1:0] cur_coord [MAX_RANK];
    logic [DIM_BITS-1:0] cur_rep   [MAX_RANK];
    logic [DIM_BITS-1:0] n_coord   [MAX_RANK];
    logic [DIM_BITS-1:0] n_rep     [MAX_RANK];
    logic [MAX_RANK:0]   carry;
    logic                n_last;

    always_comb begin
        logic coord_more;
        logic rep_more;
        carry[0] = 1'b1;
        n_last   = 1'b1;
        for (int a = 0; a < MAX_RANK; a++) begin
            cur_coord[a] = i_req.restart ? '0 : r_coord[a];
            cur_rep[a]   = i_req.restart ? '0 : r_rep[a];
            coord_more = ({1'b0, cur_coord[a]} + (DIM_BITS + 1)'(1)) < {1'b0, dim_eff[a]};
            rep_more   = ({1'b0, cur_rep[a]} + (DIM_BITS + 1)'(1)) < {1'b0, rep_eff[a]};
            if (coord_more || rep_more) n_last = 1'b0;
            n_coord[a] = cur_coord[a];
            n_rep[a]   = cur_rep[a];
            if (carry[a]) begin
                if (coord_more) begin
                    n_coord[a] = cur_coord[a] + DIM_BITS'(1);
                end else begin
                    n_coord[a] = '0;
                    n_rep[a]   = rep_more ? cur_rep[a] + DIM_BITS'(1) : '0;
                end
            end
            carry[a+1] = carry[a] && !coord_more && !rep_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_RANK; a++) begin
                r_coord[a] <= '0;
                r_rep[a]   <= '0;
            end
        end else if (req_acc) begin
            r_coord <= n_coord;
            r_rep   <= n_rep;
        end
    end

    // Stage 1: coordinate snapshot
    logic [DIM_BITS-1:0] r_s1_coord [MAX_RANK];
    logic                r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= req_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_coord <= cur_coord;
            r_s1_last  <= n_last;
        end
    end

    // Stage 2: per-axis byte offsets
    t_offset r_s2_prod [MAX_RANK];
    logic    r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            for (int a = 0; a < MAX_RANK; a++) begin
                r_s2_prod[a] <= OFFSET_W'(OFFSET_W'(r_s1_coord[a]) * step[a]);
            end
            r_s2_last <= r_s1_last;
        end
    end

    // Stage 3: offset sum into the response register
    t_offset r_out_offset;
    logic    r_out_last;
    t_offset sum_offset;

    always_comb begin
        sum_offset = '0;
        for (int a = 0; a < MAX_RANK; a++) begin
            sum_offset = sum_offset + r_s2_prod[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s2_valid) begin
            r_out_offset <= sum_offset;
            r_out_last   <= r_s2_last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.source_offset = r_out_offset;
    assign o_rsp.last          = r_out_last;

    // No request is taken while strides are being rebuilt
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stride_busy |-> !i_req.ready)
        else $error("request accepted during stride rebuild");

    // A configuration write holds off requests in the next cycle
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> !i_req.ready)
        else $error("request ready right after configuration write");

    // A restart emits element zero on the innermost axis
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.restart) |=> (r_s1_coord[0] == '0))
        else $error("restart did not start at element zero");

    // After the final element the innermost and outermost counters return to zero
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && n_last) |=> (r_coord[MAX_RANK-1] == '0 && r_rep[MAX_RANK-1] == '0
                                 && r_coord[0] == '0 && r_rep[0] == '0))
        else $error("counters did not wrap after last element");

endmodule
